>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL; the bodies vanish when SYNTH is defined.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
`define ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define ASSERT_ALWAYS(lbl, cond, msg)
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

>>> rtl/echte_pkg.sv
// Types and constants of the embedded controller host transaction engine.
`timescale 1ns / 1ps

package echte_pkg;

  typedef enum logic [5:0] {
    PH_IDLE   = 6'b000001,
    PH_W_CMD  = 6'b000010,
    PH_W_ADDR = 6'b000100,
    PH_W_DATA = 6'b001000,
    PH_W_OBF  = 6'b010000,
    PH_W_READ = 6'b100000
  } phase_t;

  // What follows the optional first result of a beat.
  typedef enum logic [2:0] {
    TK_NONE,
    TK_STATUS,
    TK_RDATA,
    TK_WAIT,
    TK_ATTEMPT,
    TK_FINISH
  } tail_t;

  localparam logic [2:0] ACT_STATUS = 3'd0;
  localparam logic [2:0] ACT_CMD    = 3'd1;
  localparam logic [2:0] ACT_WDATA  = 3'd2;
  localparam logic [2:0] ACT_RDATA  = 3'd3;
  localparam logic [2:0] ACT_DONE   = 3'd4;

  localparam logic [7:0] EC_OBF    = 8'h01;
  localparam logic [7:0] EC_IBF    = 8'h02;
  localparam logic [7:0] CMD_READ  = 8'h80;
  localparam logic [7:0] CMD_WRITE = 8'h81;

  localparam logic OP_REQUEST = 1'b0;

  localparam logic [1:0] CFG_RETRY  = 2'd0;
  localparam logic [1:0] CFG_POLL   = 2'd1;
  localparam logic [1:0] CFG_ENDIAN = 2'd2;

  localparam logic [3:0] ATTEMPT_MAX = 4'd15;

  typedef struct packed {
    logic [2:0]  action;
    logic [7:0]  port_byte;
    logic        success;
    logic [15:0] read_value;
  } res_t;

  localparam res_t RES_STATUS = '{ACT_STATUS, 8'h00, 1'b0, 16'h0000};
  localparam res_t RES_RDATA  = '{ACT_RDATA, 8'h00, 1'b0, 16'h0000};
  localparam res_t RES_FAIL   = '{ACT_DONE, 8'h00, 1'b0, 16'h0000};

endpackage

>>> rtl/ec_host_transaction_engine_core.sv
// Host side transaction engine for the embedded controller port handshake.
// The first result of an input beat is registered and shown in the cycle after the beat is taken.
// Throughput: one input beat per cycle while each causes at most one result and the
// output is not stalled; a beat with two results holds the input while the output drains.
// Reset (rst, synchronous) returns to idle, empties the output and loads the
// register defaults: 5 attempts, 100 polls per wait, high byte first in words.
`timescale 1ns / 1ps

`include "assert_macros.svh"

module ec_host_transaction_engine_core
  import echte_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [9:0]  cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        opcode,
  input  logic        is_write,
  input  logic        is_word,
  input  logic [7:0]  reg_addr,
  input  logic [15:0] write_value,
  input  logic [7:0]  port_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  action,
  output logic [7:0]  port_byte,
  output logic        success,
  output logic [15:0] read_value,
  output logic        last
);

  logic [3:0]  retry_limit;
  logic [9:0]  poll_limit;
  logic        hi_first;

  phase_t      phase, phase_next;
  logic [9:0]  poll_count, poll_count_next;
  logic [3:0]  attempt_count, attempt_count_next;
  logic        req_write, req_write_next;
  logic        req_word, req_word_next;
  logic [7:0]  req_addr, req_addr_next;
  logic [15:0] req_data, req_data_next;
  logic        second_byte, second_byte_next;
  logic [7:0]  first_read_byte, first_read_byte_next;

  res_t        res0, res1;
  logic [1:0]  cnt;

  logic        in_take;
  logic        out_take;

  res_t        pre;
  logic        pre_v;
  res_t        tail;
  logic        tail_v;
  tail_t       tk;
  logic [3:0]  tk_ac;
  phase_t      tk_wait;
  logic [15:0] tk_val;
  logic        status_ok;
  logic [9:0]  poll_inc;
  logic [3:0]  ac_inc;
  logic [7:0]  wbyte;

  assign cfg_ready = 1'b1;

  // The output holds at most one input's results, so the input waits only
  // while those results cannot all be gone by the end of this cycle.
  assign in_stall  = (cnt == 2'd2) || ((cnt == 2'd1) && out_stall);
  assign in_take   = in_valid && !in_stall;
  assign out_valid = (cnt != 2'd0);
  assign out_take  = out_valid && !out_stall;

  assign action     = res0.action;
  assign port_byte  = res0.port_byte;
  assign success    = res0.success;
  assign read_value = res0.read_value;
  assign last       = (cnt == 2'd1);

  assign status_ok = (phase == PH_W_OBF) ? |(port_value & EC_OBF)
                                         : ~|(port_value & EC_IBF);
  assign poll_inc  = poll_count + 10'd1;
  assign ac_inc    = (attempt_count < ATTEMPT_MAX) ? attempt_count + 4'd1 : attempt_count;

  always_comb begin
    if (!req_word) begin
      wbyte = req_data[7:0];
    end else if (hi_first) begin
      wbyte = second_byte ? req_data[7:0] : req_data[15:8];
    end else begin
      wbyte = second_byte ? req_data[15:8] : req_data[7:0];
    end
  end

  always_comb begin
    phase_next           = phase;
    poll_count_next      = poll_count;
    attempt_count_next   = attempt_count;
    req_write_next       = req_write;
    req_word_next        = req_word;
    req_addr_next        = req_addr;
    req_data_next        = req_data;
    second_byte_next     = second_byte;
    first_read_byte_next = first_read_byte;
    pre_v   = 1'b0;
    pre     = RES_STATUS;
    tk      = TK_NONE;
    tk_ac   = attempt_count;
    tk_wait = phase;
    tk_val  = 16'h0000;
    tail_v  = 1'b0;
    tail    = RES_STATUS;

    if (in_take) begin
      if (opcode == OP_REQUEST) begin
        if (phase == PH_IDLE) begin
          req_write_next       = is_write;
          req_word_next        = is_word;
          req_addr_next        = reg_addr;
          req_data_next        = write_value;
          second_byte_next     = 1'b0;
          first_read_byte_next = 8'h00;
          tk    = TK_ATTEMPT;
          tk_ac = 4'd0;
        end
      end else if (phase == PH_W_READ) begin
        if (!req_word) begin
          tk     = TK_FINISH;
          tk_val = {8'h00, port_value};
        end else if (!second_byte) begin
          first_read_byte_next = port_value;
          second_byte_next     = 1'b1;
          tk    = TK_ATTEMPT;
          tk_ac = 4'd0;
        end else begin
          tk     = TK_FINISH;
          tk_val = hi_first ? {first_read_byte, port_value}
                            : {port_value, first_read_byte};
        end
      end else if (phase != PH_IDLE) begin
        if (!status_ok) begin
          poll_count_next = poll_inc;
          if (poll_inc >= poll_limit) begin
            tk    = TK_ATTEMPT;
            tk_ac = ac_inc;
          end else begin
            tk = TK_STATUS;
          end
        end else begin
          unique case (phase)
            PH_W_CMD: begin
              pre_v   = 1'b1;
              pre     = '{ACT_CMD, req_write ? CMD_WRITE : CMD_READ, 1'b0, 16'h0000};
              tk      = TK_WAIT;
              tk_wait = PH_W_ADDR;
            end
            PH_W_ADDR: begin
              pre_v   = 1'b1;
              pre     = '{ACT_WDATA, req_addr + {7'd0, second_byte}, 1'b0, 16'h0000};
              tk      = TK_WAIT;
              tk_wait = PH_W_DATA;
            end
            PH_W_DATA: begin
              if (!req_write) begin
                tk      = TK_WAIT;
                tk_wait = PH_W_OBF;
              end else begin
                pre_v = 1'b1;
                pre   = '{ACT_WDATA, wbyte, 1'b0, 16'h0000};
                if (req_word && !second_byte) begin
                  second_byte_next = 1'b1;
                  tk    = TK_ATTEMPT;
                  tk_ac = 4'd0;
                end else begin
                  tk = TK_FINISH;
                end
              end
            end
            PH_W_OBF: begin
              phase_next = PH_W_READ;
              tk         = TK_RDATA;
            end
            default: begin
              tk = TK_NONE;
            end
          endcase
        end
      end
    end

    case (tk)
      TK_STATUS: begin
        tail_v = 1'b1;
        tail   = RES_STATUS;
      end
      TK_RDATA: begin
        tail_v = 1'b1;
        tail   = RES_RDATA;
      end
      TK_WAIT: begin
        tail_v = 1'b1;
        // With no polls allowed the wait fails at once and counts an attempt; no retry is started.
        if (poll_limit == 10'd0) begin
          attempt_count_next = ac_inc;
          phase_next         = PH_IDLE;
          tail               = RES_FAIL;
        end else begin
          phase_next      = tk_wait;
          poll_count_next = 10'd0;
          tail            = RES_STATUS;
        end
      end
      TK_ATTEMPT: begin
        tail_v             = 1'b1;
        attempt_count_next = tk_ac;
        if ((tk_ac >= retry_limit) || (poll_limit == 10'd0)) begin
          phase_next = PH_IDLE;
          tail       = RES_FAIL;
        end else begin
          phase_next      = PH_W_CMD;
          poll_count_next = 10'd0;
          tail            = RES_STATUS;
        end
      end
      TK_FINISH: begin
        tail_v     = 1'b1;
        phase_next = PH_IDLE;
        tail       = '{ACT_DONE, 8'h00, 1'b1, tk_val};
      end
      default: begin
        tail_v = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      retry_limit <= 4'd5;
      poll_limit  <= 10'd100;
      hi_first    <= 1'b1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_RETRY:  retry_limit <= cfg_data[3:0];
        CFG_POLL:   poll_limit  <= cfg_data;
        CFG_ENDIAN: hi_first    <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= PH_IDLE;
      poll_count      <= 10'd0;
      attempt_count   <= 4'd0;
      req_write       <= 1'b0;
      req_word        <= 1'b0;
      req_addr        <= 8'h00;
      req_data        <= 16'h0000;
      second_byte     <= 1'b0;
      first_read_byte <= 8'h00;
    end else begin
      phase           <= phase_next;
      poll_count      <= poll_count_next;
      attempt_count   <= attempt_count_next;
      req_write       <= req_write_next;
      req_word        <= req_word_next;
      req_addr        <= req_addr_next;
      req_data        <= req_data_next;
      second_byte     <= second_byte_next;
      first_read_byte <= first_read_byte_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt <= 2'd0;
    end else if (in_take) begin
      cnt <= {1'b0, pre_v} + {1'b0, tail_v};
    end else if (out_take) begin
      cnt <= cnt - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      res0 <= pre_v ? pre : tail;
      res1 <= tail;
    end else if (out_take) begin
      res0 <= res1;
    end
  end

  `ASSERT_ALWAYS(a_cnt_range, cnt != 2'd3, "result count out of range")
  `ASSERT_IMPLIES(a_done_last, out_valid && (action == ACT_DONE), last,
                  "complete beat not marked last")
  `ASSERT_IMPLIES(a_pair_order, cnt == 2'd2, res0.action != ACT_DONE,
                  "complete beat queued ahead of another result")
  `ASSERT_NEXT(a_request_answers, in_take && (opcode == OP_REQUEST) && (phase == PH_IDLE),
               out_valid, "request beat produced no result")

endmodule
